@@ hw/rtl/salsa20_8_core_block_assert.svh @@
// Assertion macros shared by the checker.
`ifndef SALSA20_8_CORE_BLOCK_ASSERT_SVH
`define SALSA20_8_CORE_BLOCK_ASSERT_SVH

// Condition must never hold while out of reset.
`define S208_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("s208 check failed: never");

// Antecedent at one edge implies consequent at the next.
`define S208_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("s208 check failed: next");

`endif

@@ hw/rtl/s208_pkg.sv @@
package s208_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    S_LOAD,
    S_GATHER,
    S_COMPUTE,
    S_OUT_RD,
    S_OUT_ADD,
    S_OUT_HOLD
  } state_t;

  // Rotate amount of each quarter-round step, in step order
  typedef enum logic [1:0] {
    ROT_7,
    ROT_9,
    ROT_13,
    ROT_18
  } rot_t;

  localparam int unsigned WORD_W = 32;

  localparam logic [3:0] LAST_WORD_IDX = 4'd15;
  localparam logic [2:0] GATHER_LAST   = 3'd4;  // last gather index: four reads, then a drain
  localparam logic [1:0] LAST_STEP     = 2'd3;
  localparam logic [2:0] LAST_QR       = 3'd7;
  localparam logic [1:0] LAST_DR       = 2'd3;  // four double rounds = eight rounds

  // Word indexes (a, b, c, d) of the eight quarter-rounds of a double round
  localparam logic [3:0] QR_LANE [0:7][0:3] = '{
    '{4'd0,  4'd4,  4'd8,  4'd12},
    '{4'd5,  4'd9,  4'd13, 4'd1 },
    '{4'd10, 4'd14, 4'd2,  4'd6 },
    '{4'd15, 4'd3,  4'd7,  4'd11},
    '{4'd0,  4'd1,  4'd2,  4'd3 },
    '{4'd5,  4'd6,  4'd7,  4'd4 },
    '{4'd10, 4'd11, 4'd8,  4'd9 },
    '{4'd15, 4'd12, 4'd13, 4'd14}
  };

  // Control bundle from sequencer to datapath
  typedef struct packed {
    logic       load_we;    // store an input beat in both memories
    logic       step_en;    // one quarter-round step, write back result
    logic       win_shift;  // shift read data into the window
    logic       out_load;   // capture sum into the output register
    logic       last;       // current output is word 15
    rot_t       rot_sel;
    logic [3:0] rd_addr;
    logic [3:0] wr_addr;
  } ctl_t;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                             input int unsigned n);
    rotl = (v << n) | (v >> (WORD_W - n));
  endfunction

endpackage

@@ hw/rtl/s208_qstep.sv @@
// Shared step unit: t ^ rotl(x + y, amount)
module s208_qstep (
  input  logic [31:0]   x,
  input  logic [31:0]   y,
  input  logic [31:0]   t,
  input  s208_pkg::rot_t rot_sel,
  output logic [31:0]   res
);

  logic [31:0] sum;
  logic [31:0] rot;

  assign sum = x + y;

  always_comb begin
    unique case (rot_sel)
      s208_pkg::ROT_7:  rot = s208_pkg::rotl(sum, 7);
      s208_pkg::ROT_9:  rot = s208_pkg::rotl(sum, 9);
      s208_pkg::ROT_13: rot = s208_pkg::rotl(sum, 13);
      s208_pkg::ROT_18: rot = s208_pkg::rotl(sum, 18);
      default:          rot = sum;
    endcase
  end

  assign res = t ^ rot;

endmodule

@@ hw/rtl/s208_ctrl.sv @@
// Sequencer: load, gather/compute per quarter-round, then output
module s208_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           out_ready,
  output logic           in_ready,
  output logic           out_valid,
  output s208_pkg::ctl_t ctl
);

  s208_pkg::state_t state, state_next;
  logic [3:0] k, k_next;     // word index for load and output
  logic [2:0] cnt, cnt_next; // gather cycle or step index
  logic [2:0] qr, qr_next;   // quarter-round within double round
  logic [1:0] dr, dr_next;   // double round

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      s208_pkg::S_LOAD:
        if (in_valid && k == s208_pkg::LAST_WORD_IDX) state_next = s208_pkg::S_GATHER;
      s208_pkg::S_GATHER:
        if (cnt == s208_pkg::GATHER_LAST) state_next = s208_pkg::S_COMPUTE;
      s208_pkg::S_COMPUTE:
        if (cnt[1:0] == s208_pkg::LAST_STEP) begin
          if (qr == s208_pkg::LAST_QR && dr == s208_pkg::LAST_DR) begin
            state_next = s208_pkg::S_OUT_RD;
          end else begin
            state_next = s208_pkg::S_GATHER;
          end
        end
      s208_pkg::S_OUT_RD:  state_next = s208_pkg::S_OUT_ADD;
      s208_pkg::S_OUT_ADD: state_next = s208_pkg::S_OUT_HOLD;
      s208_pkg::S_OUT_HOLD:
        if (out_ready) begin
          state_next = (k == s208_pkg::LAST_WORD_IDX) ? s208_pkg::S_LOAD
                                                      : s208_pkg::S_OUT_RD;
        end
      default: state_next = s208_pkg::S_LOAD;
    endcase
  end

  // Counters
  always_comb begin
    k_next   = k;
    cnt_next = cnt;
    qr_next  = qr;
    dr_next  = dr;
    unique case (state)
      s208_pkg::S_LOAD:
        if (in_valid) begin
          k_next   = 4'(k + 4'd1);  // wraps to 0 after word 15
          cnt_next = '0;
          qr_next  = '0;
          dr_next  = '0;
        end
      s208_pkg::S_GATHER:
        cnt_next = (cnt == s208_pkg::GATHER_LAST) ? 3'd0 : 3'(cnt + 3'd1);
      s208_pkg::S_COMPUTE:
        if (cnt[1:0] == s208_pkg::LAST_STEP) begin
          cnt_next = '0;
          qr_next  = 3'(qr + 3'd1);
          if (qr == s208_pkg::LAST_QR) dr_next = 2'(dr + 2'd1);
        end else begin
          cnt_next = 3'(cnt + 3'd1);
        end
      s208_pkg::S_OUT_HOLD:
        if (out_ready) k_next = 4'(k + 4'd1);
      default: ;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    ctl           = '0;
    ctl.rot_sel   = s208_pkg::rot_t'(cnt[1:0]);
    ctl.rd_addr   = k;
    ctl.wr_addr   = k;
    ctl.last      = (k == s208_pkg::LAST_WORD_IDX);
    unique case (state)
      s208_pkg::S_LOAD: begin
        in_ready    = 1'b1;
        ctl.load_we = in_valid;
      end
      s208_pkg::S_GATHER: begin
        ctl.rd_addr   = s208_pkg::QR_LANE[qr][cnt[1:0]];
        ctl.win_shift = (cnt != 3'd0);
      end
      s208_pkg::S_COMPUTE: begin
        // target of step s is lane (s+1) mod 4
        ctl.step_en = 1'b1;
        ctl.wr_addr = s208_pkg::QR_LANE[qr][2'(cnt[1:0] + 2'd1)];
      end
      s208_pkg::S_OUT_ADD:  ctl.out_load = 1'b1;
      s208_pkg::S_OUT_HOLD: out_valid    = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= s208_pkg::S_LOAD;
      k     <= '0;
      cnt   <= '0;
      qr    <= '0;
      dr    <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
      cnt   <= cnt_next;
      qr    <= qr_next;
      dr    <= dr_next;
    end
  end

endmodule

@@ hw/rtl/salsa20_8_core_block.sv @@
// Channel | Signals                          | Beat
// in      | in_valid, in_ready, in_word      | one input word, index 0..15
// out     | out_valid, out_ready, out_word,  | one result word, index 0..15;
//         | last_word                        | last_word marks word 15
// Input words 0..15 are taken one per cycle; word 15 starts the core.
// Core: 32 quarter-rounds, each a gather (4 reads + drain) then the steps, paced
// by the single read port of the working memory and the one shared step unit.
// Output: each word goes through memory read, add and hold; the next word's read
// starts only once the current one is taken. Not ready for input from word 15
// until the last output beat is taken. Synchronous reset drops a partial block.
module salsa20_8_core_block (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_word,
  output logic        last_word
);

  s208_pkg::ctl_t ctl;

  logic [31:0] store_mem [16];
  logic [31:0] work_mem  [16];
  logic [31:0] store_rd;
  logic [31:0] work_rd;
  logic [31:0] win [4];  // quarter-round window, rotated each step
  logic [31:0] step_res;

  s208_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .ctl       (ctl)
  );

  // step: x = a-side operand, y = d-side operand, t = target
  s208_qstep u_qstep (
    .x       (win[0]),
    .y       (win[3]),
    .t       (win[1]),
    .rot_sel (ctl.rot_sel),
    .res     (step_res)
  );

  // Input store and working memory, one write and one read address each
  always_ff @(posedge clk) begin
    if (ctl.load_we) begin
      store_mem[ctl.wr_addr] <= in_word;
      work_mem[ctl.wr_addr]  <= in_word;
    end else if (ctl.step_en) begin
      work_mem[ctl.wr_addr]  <= step_res;
    end
    store_rd <= store_mem[ctl.rd_addr];
    work_rd  <= work_mem[ctl.rd_addr];
  end

  // Window: shift in gathered words, or step and rotate so fixed taps line up
  always_ff @(posedge clk) begin
    if (ctl.win_shift) begin
      win[0] <= win[1];
      win[1] <= win[2];
      win[2] <= win[3];
      win[3] <= work_rd;
    end else if (ctl.step_en) begin
      win[0] <= step_res;
      win[1] <= win[2];
      win[2] <= win[3];
      win[3] <= win[0];
    end
  end

  // Output register: feed-forward add
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_word  <= work_rd + store_rd;
      last_word <= ctl.last;
    end
  end

endmodule

@@ hw/rtl/s208_checker.sv @@
`include "salsa20_8_core_block_assert.svh"

// Port-level checks on the block's sequencing
module s208_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_word,
  input logic        last_word
);

  // input and output phases never overlap
  `S208_NEVER(a_no_overlap, in_ready && out_valid)

  // stalled result beat holds
  `S208_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word) && $stable(last_word))

  // last beat taken: block returns to input
  `S208_NEXT(a_last_done, out_valid && out_ready && last_word, !out_valid && in_ready)

  // mid-block beat taken: still outputting
  `S208_NEXT(a_mid_block, out_valid && out_ready && !last_word, !in_ready)

endmodule

bind salsa20_8_core_block s208_checker u_s208_checker (.*);
